FILE: design/u8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned REM_W    = 2;
    localparam int unsigned PAYLOAD_W = 6;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_TRUNC    = 2'd2
    } t_status;

    typedef struct packed {
        logic [CP_W-1:0]  acc;
        logic [REM_W-1:0] rem;
        logic             halted;
    } t_state;

    typedef struct packed {
        logic             emit;
        logic [CP_W-1:0]  code_point;
        t_status          status;
        logic             buffer_end;
    } t_result;

endpackage : u8d_pkg
`default_nettype wire

FILE: design/u8d_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_step
// Combinational decode of one byte against the current decoder state.
// ----------------------------------------------------------------------------
module u8d_step (
    input  wire u8d_pkg::t_state              i_state,
    input  wire logic [u8d_pkg::BYTE_W-1:0]   i_byte_in,
    input  wire logic                         i_buffer_last,
    output u8d_pkg::t_state                   o_state,
    output u8d_pkg::t_result                  o_result
);
    import u8d_pkg::*;

    logic [CP_W-1:0]  shifted;
    logic [REM_W-1:0] rem_dec;
    logic             lead_open;

    assign shifted = {i_state.acc[CP_W-PAYLOAD_W-1:0], i_byte_in[PAYLOAD_W-1:0]};
    assign rem_dec = i_state.rem - REM_W'(1);

    always_comb begin
        o_state             = i_state;
        o_result.emit       = 1'b0;
        o_result.code_point = '0;
        o_result.status     = ST_OK;
        o_result.buffer_end = i_buffer_last;
        lead_open           = 1'b0;

        if (i_state.halted) begin
            // Bytes after a bad lead are dropped until the buffer ends.
            if (i_buffer_last) begin
                o_state = '0;
            end
        end else if (i_state.rem != '0) begin
            if (rem_dec == '0) begin
                o_state             = '0;
                o_result.emit       = 1'b1;
                o_result.code_point = shifted;
            end else if (i_buffer_last) begin
                o_state             = '0;
                o_result.emit       = 1'b1;
                o_result.status     = ST_TRUNC;
            end else begin
                o_state.acc = shifted;
                o_state.rem = rem_dec;
            end
        end else begin
            unique casez (i_byte_in)
                8'b0???_????: begin
                    o_result.emit       = 1'b1;
                    o_result.code_point = CP_W'(i_byte_in);
                end
                8'b110?_????: begin
                    o_state.acc = CP_W'(i_byte_in[4:0]);
                    o_state.rem = REM_W'(1);
                    lead_open   = 1'b1;
                end
                8'b1110_????: begin
                    o_state.acc = CP_W'(i_byte_in[3:0]);
                    o_state.rem = REM_W'(2);
                    lead_open   = 1'b1;
                end
                8'b1111_0???: begin
                    o_state.acc = CP_W'(i_byte_in[2:0]);
                    o_state.rem = REM_W'(3);
                    lead_open   = 1'b1;
                end
                default: begin
                    o_state             = '0;
                    o_state.halted      = ~i_buffer_last;
                    o_result.emit       = 1'b1;
                    o_result.status     = ST_BAD_LEAD;
                end
            endcase

            // A multi-byte lead on the buffer's last byte can never complete.
            if (lead_open && i_buffer_last) begin
                o_state             = '0;
                o_result.emit       = 1'b1;
                o_result.status     = ST_TRUNC;
            end
        end
    end

endmodule : u8d_step
`default_nettype wire

FILE: design/utf8_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream, one byte per item, into 21-bit code points.
// ----------------------------------------------------------------------------
// Input channel: one raw byte per item with a flag on the last byte of a buffer.
// Output channel: a code point with a status (ok, invalid lead, truncated) and a
// flag telling that the item was caused by the buffer's last byte.
// Path: an accepted byte is held in the input register, decoded, and its result
// is written to the output register once it is free. Throughput is one byte per
// cycle unless a result waits behind a held one; the only work per byte is the
// lead-byte decode and a six-bit shift of the accumulator.
// Bytes that produce no result (lead and middle bytes of a sequence, bytes
// dropped after an invalid lead) pass the output register without using it.
// Reset clears the decoder state and both valid flags. When the receiver
// stalls, the held result stays put, the input register keeps draining bytes
// that produce no result, and input ready drops only once a byte that needs
// the output register is waiting behind the held result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [u8d_pkg::BYTE_W-1:0]     i_byte_in,
    input  wire logic                           i_buffer_last,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [u8d_pkg::CP_W-1:0]            o_code_point,
    output logic [u8d_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_buffer_end
);
    import u8d_pkg::*;

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_last;
    t_state              r_state;
    t_state              n_state;
    t_result             step_res;
    logic                r_out_valid;
    logic [CP_W-1:0]     r_cp;
    t_status             r_status;
    logic                r_bend;
    logic                out_free;
    logic                s1_adv;

    u8d_step u_step (
        .i_state       (r_state),
        .i_byte_in     (r_byte),
        .i_buffer_last (r_last),
        .o_state       (n_state),
        .o_result      (step_res)
    );

    assign out_free   = ~r_out_valid | i_out_ready;
    assign s1_adv     = r_in_valid & (~step_res.emit | out_free);
    assign o_in_ready = ~r_in_valid | s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_state <= n_state;
            end
            if (s1_adv && step_res.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_byte_in;
            r_last <= i_buffer_last;
        end
        if (s1_adv && step_res.emit) begin
            r_cp     <= step_res.code_point;
            r_status <= step_res.status;
            r_bend   <= step_res.buffer_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_cp;
    assign o_status     = r_status;
    assign o_buffer_end = r_bend;

    // Any error result carries a zero code point.
    a_err_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_cp == '0))
        else $error("error result with nonzero code point");

    // A truncated sequence is only reported on the buffer's last byte.
    a_trunc_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_TRUNC) |-> r_bend)
        else $error("truncation reported away from buffer end");

    // Every buffer end leaves the decoder at its reset state.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_last) |=> (r_state == '0))
        else $error("state not cleared at buffer end");

    // While halted no sequence may be open.
    a_halt_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |-> (r_state.rem == '0 && r_state.acc == '0))
        else $error("sequence open while halted");

endmodule : utf8_stream_decoder
`default_nettype wire
